// ===== src/tvce_pkg.sv =====
// Shared types, constants and lookup functions for the turtle vector command engine.
`default_nettype none

package tvce_pkg;

   localparam int AMOUNT_W      = 32;
   localparam int COORD_W       = 16;
   localparam int HEADING_W     = 16;
   localparam int POS_W         = 32;
   localparam int COLOR_W       = 32;
   localparam int LWIDTH_W      = 8;
   localparam int DASH_W        = 4;
   localparam int CMD_W         = 3;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int ATAN_W        = 22;
   localparam int ATAN_INDEX_W  = 5;
   localparam int ATAN_ENTRIES  = 24;

   // CORDIC gain compensation, 0.60725293500888 in Q1.30.
   localparam logic [29:0] GAIN_Q30 = 30'd652032874;

   localparam logic [HEADING_W-1:0] QUARTER_TURN       = 16'd16384;
   localparam logic [HEADING_W-1:0] HALF_TURN          = 16'd32768;
   localparam logic [HEADING_W-1:0] THREE_QUARTER_TURN = 16'd49152;

   typedef enum logic [CMD_W-1:0] {
      CMD_PEN_UP   = 3'd0,
      CMD_PEN_DOWN = 3'd1,
      CMD_TURN     = 3'd2,
      CMD_FORWARD  = 3'd3,
      CMD_HOME     = 3'd4
   } tvce_cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_START_X       = 3'd0,
      REG_START_Y       = 3'd1,
      REG_START_HEADING = 3'd2,
      REG_LINE_COLOR    = 3'd3,
      REG_LINE_WIDTH    = 3'd4,
      REG_DASH_STYLE    = 3'd5
   } tvce_reg_type;

   typedef struct packed {
      logic [CMD_W-1:0]           cmd;
      logic signed [AMOUNT_W-1:0] amount;
   } tvce_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] from_x;
      logic signed [COORD_W-1:0] from_y;
      logic signed [COORD_W-1:0] to_x;
      logic signed [COORD_W-1:0] to_y;
      logic [COLOR_W-1:0]        seg_color;
      logic [LWIDTH_W-1:0]       seg_width;
      logic [DASH_W-1:0]         seg_dash;
   } tvce_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TURN,
      ST_FORWARD,
      ST_EMIT
   } tvce_state_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_MUL,
      CS_PREP,
      CS_ROTATE,
      CS_SCALE,
      CS_DONE
   } tvce_cordic_state_type;

   typedef enum logic [1:0] {
      DS_IDLE,
      DS_RUN,
      DS_DONE
   } tvce_div_state_type;

   // Arctangent of 2^-i with 2^24 units per full turn, rounded.
   function automatic logic [ATAN_W-1:0] atan_lookup(input logic [ATAN_INDEX_W-1:0] idx);
      logic [ATAN_W-1:0] val;
      case (idx)
         5'd0:    val = 22'd2097152;
         5'd1:    val = 22'd1238021;
         5'd2:    val = 22'd654136;
         5'd3:    val = 22'd332050;
         5'd4:    val = 22'd166669;
         5'd5:    val = 22'd83416;
         5'd6:    val = 22'd41718;
         5'd7:    val = 22'd20860;
         5'd8:    val = 22'd10430;
         5'd9:    val = 22'd5215;
         5'd10:   val = 22'd2608;
         5'd11:   val = 22'd1304;
         5'd12:   val = 22'd652;
         5'd13:   val = 22'd326;
         5'd14:   val = 22'd163;
         5'd15:   val = 22'd81;
         5'd16:   val = 22'd41;
         5'd17:   val = 22'd20;
         5'd18:   val = 22'd10;
         5'd19:   val = 22'd5;
         5'd20:   val = 22'd3;
         5'd21:   val = 22'd1;
         5'd22:   val = 22'd1;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

   // Integer pixel of a Q16.16 value, rounded toward zero: floor, plus one
   // for a negative value that has a nonzero fraction.
   function automatic logic [COORD_W-1:0] trunc_pixel(input logic [POS_W-1:0] p);
      logic fix;
      fix = p[POS_W-1] & (|p[15:0]);
      return p[POS_W-1:16] + COORD_W'(fix);
   endfunction

endpackage

`default_nettype wire

// ===== src/tvce_if.sv =====
// Valid/ready channel interfaces for the command and segment words.
`default_nettype none

interface tvce_req_if;
   logic                  valid;
   logic                  ready;
   tvce_pkg::tvce_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tvce_rsp_if;
   logic                  valid;
   logic                  ready;
   tvce_pkg::tvce_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/tvce_divider.sv =====
// Turn unit that converts a turn amount in degrees into a binary-angle step by reciprocal multiply.
`default_nettype none

module tvce_divider (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic signed [tvce_pkg::AMOUNT_W-1:0]   amount,
   output logic                                        done,
   output logic [tvce_pkg::HEADING_W-1:0]              delta
);

   localparam int MAG_W   = 33;
   localparam int N_W     = 29;
   localparam int PROD_W  = 51;
   localparam int Q_SHIFT = 35;
   localparam int AW      = tvce_pkg::AMOUNT_W;
   localparam int HW      = tvce_pkg::HEADING_W;
   // ceil(2^35 / 45); the quotient is exact for every numerator below 2^29.
   localparam logic [29:0] RECIP_45 = 30'd763549742;

   tvce_pkg::tvce_div_state_type state_ff, state_in;
   logic [N_W-1:0]    num_ff, num_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              neg_ff, neg_in;

   logic [AW-1:0]     abs_amt;
   logic [MAG_W-1:0]  mag;
   logic [HW-1:0]     quot;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tvce_pkg::DS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      num_ff  <= num_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
   end

   always_comb begin
      abs_amt  = amount[AW-1] ? (~amount + 1'b1) : amount;
      // Magnitude of 2 * amount + 360 * sign; dividing it by 720 is a shift by
      // four followed by a division by 45.
      mag      = {abs_amt, 1'b0} + MAG_W'(360);
      quot     = prod_ff[Q_SHIFT+HW-1:Q_SHIFT];
      state_in = state_ff;
      num_in   = num_ff;
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      done     = 1'b0;
      unique case (state_ff)
         tvce_pkg::DS_IDLE: begin
            if (start) begin
               num_in   = mag[MAG_W-1:4];
               neg_in   = amount[AW-1];
               state_in = tvce_pkg::DS_RUN;
            end
         end
         tvce_pkg::DS_RUN: begin
            // Only the low bits of the product up to the quotient field are kept.
            prod_in  = PROD_W'(num_ff) * PROD_W'(RECIP_45);
            state_in = tvce_pkg::DS_DONE;
         end
         tvce_pkg::DS_DONE: begin
            done     = 1'b1;
            state_in = tvce_pkg::DS_IDLE;
         end
         default: state_in = tvce_pkg::DS_IDLE;
      endcase
   end

   assign delta = neg_ff ? (~quot + 1'b1) : quot;

endmodule

`default_nettype wire

// ===== src/tvce_cordic.sv =====
// Iterative CORDIC rotator that turns a forward distance into an x and y step.
`default_nettype none

module tvce_cordic #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS    = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [tvce_pkg::AMOUNT_W-1:0]  amount,
   input  wire logic [tvce_pkg::HEADING_W-1:0]        heading,
   output logic                                       done,
   output logic [tvce_pkg::POS_W-1:0]                 step_x,
   output logic [tvce_pkg::POS_W-1:0]                 step_y
);

   localparam int VEC_W     = FRAC_BITS + 18;
   localparam int ANGLE_W   = 26;
   localparam int GAIN_W    = 31;
   localparam int PROD_W    = 63;
   localparam int RND_SHIFT = 46 - FRAC_BITS;
   localparam int CNT_W     = $clog2(CORDIC_STEPS);
   localparam int AW        = tvce_pkg::AMOUNT_W;
   localparam int HW        = tvce_pkg::HEADING_W;
   localparam int PW        = tvce_pkg::POS_W;

   tvce_pkg::tvce_cordic_state_type state_ff, state_in;
   logic signed [AW-1:0]      amt_ff, amt_in;
   logic [HW-1:0]             head_ff, head_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [VEC_W-1:0]   x_ff, x_in;
   logic signed [VEC_W-1:0]   y_ff, y_in;
   logic signed [ANGLE_W-1:0] z_ff, z_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [PW-1:0]             step_x_ff, step_x_in;
   logic [PW-1:0]             step_y_ff, step_y_in;

   logic signed [GAIN_W-1:0]  gain_s;
   logic signed [PROD_W-1:0]  rnd;
   logic signed [VEC_W-1:0]   x0;
   logic                      flip;
   logic [HW-1:0]             h_adj;
   logic signed [ANGLE_W-1:0] z0;
   logic signed [VEC_W-1:0]   x_shr;
   logic signed [VEC_W-1:0]   y_shr;
   logic signed [ANGLE_W-1:0] at_s;
   logic signed [63:0]        x_wide;
   logic signed [63:0]        y_wide;
   logic [PW-1:0]             scaled_x;
   logic [PW-1:0]             scaled_y;

   assign x_wide = 64'(x_ff);
   assign y_wide = 64'(y_ff);

   // Final rescale to 16 fraction bits; scaling down rounds half up.
   generate
      if (FRAC_BITS <= 16) begin : g_scale_up
         assign scaled_x = PW'(x_wide <<< (16 - FRAC_BITS));
         assign scaled_y = PW'(y_wide <<< (16 - FRAC_BITS));
      end else begin : g_scale_down
         assign scaled_x = PW'((x_wide + (64'sd1 <<< (FRAC_BITS - 17))) >>> (FRAC_BITS - 16));
         assign scaled_y = PW'((y_wide + (64'sd1 <<< (FRAC_BITS - 17))) >>> (FRAC_BITS - 16));
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tvce_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      amt_ff    <= amt_in;
      head_ff   <= head_in;
      prod_ff   <= prod_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      cnt_ff    <= cnt_in;
      step_x_ff <= step_x_in;
      step_y_ff <= step_y_in;
   end

   always_comb begin
      gain_s = $signed({1'b0, tvce_pkg::GAIN_Q30});
      rnd    = prod_ff + (PROD_W'(1) <<< (RND_SHIFT - 1));
      x0     = VEC_W'(rnd >>> RND_SHIFT);
      // Headings in the left half plane start from the mirrored vector.
      flip   = (head_ff > tvce_pkg::QUARTER_TURN) && (head_ff < tvce_pkg::THREE_QUARTER_TURN);
      h_adj  = flip ? (head_ff + tvce_pkg::HALF_TURN) : head_ff;
      z0     = ANGLE_W'($signed(h_adj)) <<< 8;
      x_shr  = x_ff >>> cnt_ff;
      y_shr  = y_ff >>> cnt_ff;
      at_s   = ANGLE_W'(tvce_pkg::atan_lookup(tvce_pkg::ATAN_INDEX_W'(cnt_ff)));

      state_in  = state_ff;
      amt_in    = amt_ff;
      head_in   = head_ff;
      prod_in   = prod_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      cnt_in    = cnt_ff;
      step_x_in = step_x_ff;
      step_y_in = step_y_ff;
      done      = 1'b0;

      unique case (state_ff)
         tvce_pkg::CS_IDLE: begin
            if (start) begin
               amt_in   = amount;
               head_in  = heading;
               state_in = tvce_pkg::CS_MUL;
            end
         end
         tvce_pkg::CS_MUL: begin
            prod_in  = amt_ff * gain_s;
            state_in = tvce_pkg::CS_PREP;
         end
         tvce_pkg::CS_PREP: begin
            x_in     = flip ? -x0 : x0;
            y_in     = '0;
            z_in     = z0;
            cnt_in   = '0;
            state_in = tvce_pkg::CS_ROTATE;
         end
         tvce_pkg::CS_ROTATE: begin
            // Rotate counter-clockwise while the residual angle is not negative.
            if (!z_ff[ANGLE_W-1]) begin
               x_in = x_ff - y_shr;
               y_in = y_ff + x_shr;
               z_in = z_ff - at_s;
            end else begin
               x_in = x_ff + y_shr;
               y_in = y_ff - x_shr;
               z_in = z_ff + at_s;
            end
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               state_in = tvce_pkg::CS_SCALE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         tvce_pkg::CS_SCALE: begin
            step_x_in = scaled_x;
            step_y_in = scaled_y;
            state_in  = tvce_pkg::CS_DONE;
         end
         tvce_pkg::CS_DONE: begin
            done     = 1'b1;
            state_in = tvce_pkg::CS_IDLE;
         end
         default: state_in = tvce_pkg::CS_IDLE;
      endcase
   end

   assign step_x = step_x_ff;
   assign step_y = step_y_ff;

endmodule

`default_nettype wire

// ===== src/turtle_vector_command_engine_unit.sv =====
// Top level of the turtle vector command engine: command decode, turtle state and output word.
//
// The req_port channel carries one command word (cmd, amount) per handshake; the rsp_port
// channel carries one line segment word. Both are valid/ready channels and a word moves
// at a rising clock edge where valid and ready are both high. The csr_ port writes the six
// configuration registers (start x, start y, start heading, color, width, dash) by index.
// Pen up, pen down, home and unknown commands finish in the cycle they are accepted, so
// the next command can be taken on the following edge. A turn divides by 720 with one
// reciprocal multiply in the turn unit; the next command is accepted once the turn unit
// has gone through its run and done states and the heading is updated. A forward move
// runs the CORDIC rotator, one rotation step per cycle, through its multiply, prepare,
// rotate, scale and done states; with the pen down the segment word is then registered
// onto rsp_port as the engine leaves its emit state.
// A single output register holds the segment word; the engine takes the next command while
// that word waits. If the receiver is still holding the previous segment when a new one is
// finished, the engine waits in its emit state until the output register frees up.
// Synchronous reset clears position and heading to zero, lowers the pen, returns the
// configuration registers to their reset values (line width one) and empties the output.
`default_nettype none

module turtle_vector_command_engine_unit #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS    = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   tvce_req_if.sink                                  req_port,
   tvce_rsp_if.source                                rsp_port,
   input  wire logic                                 csr_we,
   input  wire logic [tvce_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [tvce_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CW = tvce_pkg::COORD_W;
   localparam int HW = tvce_pkg::HEADING_W;
   localparam int PW = tvce_pkg::POS_W;

   // Configuration registers.
   logic [CW-1:0]                   start_x_ff;
   logic [CW-1:0]                   start_y_ff;
   logic [HW-1:0]                   start_heading_ff;
   logic [tvce_pkg::COLOR_W-1:0]    line_color_ff;
   logic [tvce_pkg::LWIDTH_W-1:0]   line_width_ff;
   logic [tvce_pkg::DASH_W-1:0]     dash_style_ff;

   // Turtle state and control.
   tvce_pkg::tvce_state_type state_ff, state_in;
   logic [PW-1:0]           pos_x_ff, pos_x_in;
   logic [PW-1:0]           pos_y_ff, pos_y_in;
   logic [HW-1:0]           heading_ff, heading_in;
   logic                    pen_down_ff, pen_down_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tvce_pkg::tvce_rsp_type  rsp_data_ff, rsp_data_in;

   logic          req_accept;
   logic          out_free;
   logic          div_start;
   logic          div_done;
   logic [HW-1:0] div_delta;
   logic          cordic_start;
   logic          cordic_done;
   logic [PW-1:0] step_x;
   logic [PW-1:0] step_y;
   logic [PW-1:0] new_x;
   logic [PW-1:0] new_y;

   tvce_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .amount (req_port.payload.amount),
      .done   (div_done),
      .delta  (div_delta)
   );

   tvce_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .amount  (req_port.payload.amount),
      .heading (heading_ff),
      .done    (cordic_done),
      .step_x  (step_x),
      .step_y  (step_y)
   );

   // Configuration writes; bits above a register's width are dropped and
   // indexes past the last register are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff       <= '0;
         start_y_ff       <= '0;
         start_heading_ff <= '0;
         line_color_ff    <= '0;
         line_width_ff    <= tvce_pkg::LWIDTH_W'(1);
         dash_style_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            tvce_pkg::REG_START_X:       start_x_ff       <= csr_wdata[CW-1:0];
            tvce_pkg::REG_START_Y:       start_y_ff       <= csr_wdata[CW-1:0];
            tvce_pkg::REG_START_HEADING: start_heading_ff <= csr_wdata[HW-1:0];
            tvce_pkg::REG_LINE_COLOR:    line_color_ff    <= csr_wdata[tvce_pkg::COLOR_W-1:0];
            tvce_pkg::REG_LINE_WIDTH:    line_width_ff    <= csr_wdata[tvce_pkg::LWIDTH_W-1:0];
            tvce_pkg::REG_DASH_STYLE:    dash_style_ff    <= csr_wdata[tvce_pkg::DASH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tvce_pkg::ST_IDLE;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         heading_ff   <= '0;
         pen_down_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         heading_ff   <= heading_in;
         pen_down_ff  <= pen_down_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_port.ready = (state_ff == tvce_pkg::ST_IDLE);
   assign req_accept     = req_port.valid && req_port.ready;
   assign out_free       = !rsp_valid_ff || rsp_port.ready;

   // Position update wraps modulo 2^32.
   assign new_x = pos_x_ff + step_x;
   assign new_y = pos_y_ff + step_y;

   always_comb begin
      state_in     = state_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      heading_in   = heading_ff;
      pen_down_in  = pen_down_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      cordic_start = 1'b0;

      unique case (state_ff)
         tvce_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_port.payload.cmd)
                  tvce_pkg::CMD_PEN_UP:   pen_down_in = 1'b0;
                  tvce_pkg::CMD_PEN_DOWN: pen_down_in = 1'b1;
                  tvce_pkg::CMD_TURN: begin
                     div_start = 1'b1;
                     state_in  = tvce_pkg::ST_TURN;
                  end
                  tvce_pkg::CMD_FORWARD: begin
                     cordic_start = 1'b1;
                     state_in     = tvce_pkg::ST_FORWARD;
                  end
                  tvce_pkg::CMD_HOME: begin
                     pos_x_in    = {start_x_ff, 16'h0000};
                     pos_y_in    = {start_y_ff, 16'h0000};
                     heading_in  = start_heading_ff;
                     pen_down_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         tvce_pkg::ST_TURN: begin
            if (div_done) begin
               heading_in = heading_ff + div_delta;
               state_in   = tvce_pkg::ST_IDLE;
            end
         end
         tvce_pkg::ST_FORWARD: begin
            if (cordic_done) begin
               state_in = tvce_pkg::ST_EMIT;
            end
         end
         tvce_pkg::ST_EMIT: begin
            // With the pen down the move waits until the output register can take
            // the segment; with the pen up it completes at once.
            if (!pen_down_ff || out_free) begin
               pos_x_in = new_x;
               pos_y_in = new_y;
               if (pen_down_ff) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.from_x    = tvce_pkg::trunc_pixel(pos_x_ff);
                  rsp_data_in.from_y    = tvce_pkg::trunc_pixel(pos_y_ff);
                  rsp_data_in.to_x      = tvce_pkg::trunc_pixel(new_x);
                  rsp_data_in.to_y      = tvce_pkg::trunc_pixel(new_y);
                  rsp_data_in.seg_color = line_color_ff;
                  rsp_data_in.seg_width = line_width_ff;
                  rsp_data_in.seg_dash  = dash_style_ff;
               end
               state_in = tvce_pkg::ST_IDLE;
            end
         end
         default: state_in = tvce_pkg::ST_IDLE;
      endcase
   end

   assign rsp_port.valid   = rsp_valid_ff;
   assign rsp_port.payload = rsp_data_ff;

endmodule

`default_nettype wire

// ===== sim/turtle_vector_command_engine_unit_tb.sv =====
// Self-checking testbench for the turtle vector command engine unit.
module turtle_vector_command_engine_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tvce_pkg::*;

   // The engine is built with its default CORDIC length and fraction width, and the
   // turtle model below follows the same figures.
   localparam int ROTATION_STEPS  = 16;
   localparam int ARCTAN_COUNT    = 24;
   localparam longint GAIN_FIXED  = 64'sd652032874;   // 0.60725... in Q1.30

   localparam int ITEMS_PER_PHASE = 140;
   localparam int PHASES          = 6;
   localparam int SETTLE_CYCLES   = 40;    // longer than a forward move
   localparam int TIMEOUT_NS      = 5_000_000;
   localparam int REPORT_LIMIT    = 60;

   // Command codes that the engine must ignore, and register indexes past the last register.
   localparam logic [CMD_W-1:0]       CMD_UNUSED_LO  = 3'd5;
   localparam logic [CMD_W-1:0]       CMD_UNUSED_MID = 3'd6;
   localparam logic [CMD_W-1:0]       CMD_UNUSED_HI  = 3'd7;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_A   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_B   = 3'd7;

   // A zero-length segment at the origin with the reset line width of one.
   localparam tvce_rsp_type RESET_DOT = '{from_x: '0, from_y: '0, to_x: '0, to_y: '0,
                                          seg_color: '0, seg_width: 8'd1, seg_dash: '0};
   localparam tvce_rsp_type NO_SEG    = '0;

   typedef struct {
      logic [CMD_W-1:0] cmd;
      logic [31:0]      amount;
      bit               typed;
      tvce_rsp_type     seg;
   } command_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   tvce_req_if req_ch ();
   tvce_rsp_if rsp_ch ();

   turtle_vector_command_engine_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_ch),
      .rsp_port  (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Turtle state and register copies kept by the testbench.
   logic [31:0] turtle_x;
   logic [31:0] turtle_y;
   logic [15:0] turtle_heading;
   bit          turtle_pen_low;
   logic [15:0] cfg_start_x;
   logic [15:0] cfg_start_y;
   logic [15:0] cfg_start_heading;
   logic [31:0] cfg_color;
   logic [7:0]  cfg_width;
   logic [3:0]  cfg_dash;

   // Arctangent of 2^-i with 2^24 units per full turn.
   longint arctan_units [0:ARCTAN_COUNT-1] = '{
      2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
      10430, 5215, 2608, 1304, 652, 326, 163, 81,
      41, 20, 10, 5, 3, 1, 1, 0
   };

   tvce_rsp_type segments_due [$];
   int           mismatch_count;
   int           segment_number;
   int unsigned  cycle_count;
   int           sender_idle_pct;
   int           receiver_stall_pct;

   // The directed opening. Rows with a typed segment are ones whose answer is obvious:
   // a zero-length move at the origin right after reset or after a home with reset
   // registers. Everything else is checked against the turtle model.
   command_row_type opening_rows [25] = '{
      '{CMD_FORWARD,    32'h0000_0000, 1'b1, RESET_DOT},
      '{CMD_PEN_UP,     32'h1234_5678, 1'b0, NO_SEG},
      '{CMD_FORWARD,    32'h000A_0000, 1'b0, NO_SEG},
      '{CMD_PEN_DOWN,   32'hFFFF_FFFF, 1'b0, NO_SEG},
      '{CMD_FORWARD,    32'h7FFF_FFFF, 1'b0, NO_SEG},
      '{CMD_FORWARD,    32'h8000_0000, 1'b0, NO_SEG},
      '{CMD_HOME,       32'hDEAD_BEEF, 1'b0, NO_SEG},
      '{CMD_FORWARD,    32'h0000_0000, 1'b1, RESET_DOT},
      '{CMD_TURN,       32'h005A_0000, 1'b0, NO_SEG},
      '{CMD_FORWARD,    32'h0007_8000, 1'b0, NO_SEG},
      '{CMD_TURN,       32'h00B4_0000, 1'b0, NO_SEG},
      '{CMD_FORWARD,    32'hFFFC_C000, 1'b0, NO_SEG},
      '{CMD_TURN,       32'h0000_00B4, 1'b0, NO_SEG},
      '{CMD_FORWARD,    32'h000C_0000, 1'b0, NO_SEG},
      '{CMD_TURN,       32'hFFFF_FF4C, 1'b0, NO_SEG},
      '{CMD_TURN,       32'hFF4C_0000, 1'b0, NO_SEG},
      '{CMD_TURN,       32'h0001_0000, 1'b0, NO_SEG},
      '{CMD_FORWARD,    32'h0064_0000, 1'b0, NO_SEG},
      '{CMD_TURN,       32'h7FFF_FFFF, 1'b0, NO_SEG},
      '{CMD_TURN,       32'h8000_0000, 1'b0, NO_SEG},
      '{CMD_FORWARD,    32'h4000_0000, 1'b0, NO_SEG},
      '{CMD_UNUSED_LO,  32'hFFFF_FFFF, 1'b0, NO_SEG},
      '{CMD_UNUSED_MID, 32'h0000_0000, 1'b0, NO_SEG},
      '{CMD_UNUSED_HI,  32'h8000_0000, 1'b0, NO_SEG},
      '{CMD_FORWARD,    32'hFFFF_FFFF, 1'b0, NO_SEG}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Idling is switched off for a recurring stretch of cycles, so that each phase also
   // sees the engine run at full rate.
   function automatic bit idle_now(input int pct);
      if ((cycle_count % 300) < 60) begin
         return 1'b0;
      end
      return $urandom_range(0, 99) < pct;
   endfunction

   // Integer pixel of a Q16.16 position, rounded toward zero.
   function automatic logic [15:0] pixel_of(input logic [31:0] pos);
      longint whole;
      longint pix;
      whole = longint'($signed(pos));
      pix = (whole >= 0) ? (whole >>> 16) : -((-whole) >>> 16);
      return pix[15:0];
   endfunction

   // Applies one command word to the turtle state. Returns one when a forward move with
   // the pen down draws a segment, which is then handed back in seg.
   function automatic bit advance_turtle(input logic [CMD_W-1:0] cmd,
                                         input logic [31:0] amount_bits,
                                         output tvce_rsp_type seg);
      longint amount;
      longint sweep;
      longint vx;
      longint vy;
      longint angle;
      longint shift_x;
      longint shift_y;
      logic [15:0] dir;
      logic [31:0] next_x;
      logic [31:0] next_y;
      bit drawn;
      drawn = 1'b0;
      seg = '0;
      amount = longint'($signed(amount_bits));
      case (cmd)
         CMD_PEN_UP: begin
            turtle_pen_low = 1'b0;
         end
         CMD_PEN_DOWN: begin
            turtle_pen_low = 1'b1;
         end
         CMD_TURN: begin
            // Degrees to binary angle: amount / 360, rounded half away from zero.
            sweep = (amount * 2 + ((amount < 0) ? -360 : 360)) / 720;
            turtle_heading = turtle_heading + sweep[15:0];
         end
         CMD_HOME: begin
            turtle_x = {cfg_start_x, 16'h0000};
            turtle_y = {cfg_start_y, 16'h0000};
            turtle_heading = cfg_start_heading;
            turtle_pen_low = 1'b1;
         end
         CMD_FORWARD: begin
            // Gain correction first, rounded half up back to 16 fraction bits.
            vx = (amount * GAIN_FIXED + (longint'(1) <<< 29)) >>> 30;
            vy = 0;
            dir = turtle_heading;
            // The rotator is fed only angles within a quarter turn of zero, so headings in
            // the back half flip the vector and rotate by half a turn.
            if (dir > QUARTER_TURN && dir < THREE_QUARTER_TURN) begin
               vx = -vx;
               dir = dir + HALF_TURN;
            end
            angle = longint'($signed(dir)) * 256;
            for (int i = 0; i < ROTATION_STEPS && i < ARCTAN_COUNT; i++) begin
               shift_x = vy >>> i;
               shift_y = vx >>> i;
               if (angle >= 0) begin
                  vx = vx - shift_x;
                  vy = vy + shift_y;
                  angle = angle - arctan_units[i];
               end else begin
                  vx = vx + shift_x;
                  vy = vy - shift_y;
                  angle = angle + arctan_units[i];
               end
            end
            next_x = turtle_x + vx[31:0];
            next_y = turtle_y + vy[31:0];
            if (turtle_pen_low) begin
               seg.from_x = pixel_of(turtle_x);
               seg.from_y = pixel_of(turtle_y);
               seg.to_x = pixel_of(next_x);
               seg.to_y = pixel_of(next_y);
               seg.seg_color = cfg_color;
               seg.seg_width = cfg_width;
               seg.seg_dash = cfg_dash;
               drawn = 1'b1;
            end
            turtle_x = next_x;
            turtle_y = next_y;
         end
         default: begin
         end
      endcase
      return drawn;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < REPORT_LIMIT) begin
         $display("%0t ns: segment %0d: %s is %h, should be %h",
                  $time, segment_number, what, got, want);
      end
      mismatch_count++;
   endtask

   // One register write. The enable stays up; the caller lowers it after the last write.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_START_X:       cfg_start_x = value[15:0];
         REG_START_Y:       cfg_start_y = value[15:0];
         REG_START_HEADING: cfg_start_heading = value[15:0];
         REG_LINE_COLOR:    cfg_color = value;
         REG_LINE_WIDTH:    cfg_width = value[7:0];
         REG_DASH_STYLE:    cfg_dash = value[3:0];
         default: begin
         end
      endcase
   endtask

   // Presents one command word, waits for the handshake, and then updates the turtle
   // state. A drawn segment is queued: the typed one where the row gives it.
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [31:0] amount,
                            input bit typed, input tvce_rsp_type typed_seg);
      tvce_req_type word;
      tvce_rsp_type predicted;
      while (idle_now(sender_idle_pct)) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      word.cmd = cmd;
      word.amount = amount;
      req_ch.valid <= 1'b1;
      req_ch.payload <= word;
      do begin
         @(posedge clock);
      end while (req_ch.ready !== 1'b1);
      if (advance_turtle(cmd, amount, predicted)) begin
         segments_due.insert(segments_due.size(), typed ? typed_seg : predicted);
      end
   endtask

   // Waits until every queued segment has come out, then lets a turn or an undrawn move
   // run to completion, since neither leaves any output to wait for.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (segments_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register settings per phase: reset values, extremes with junk above each register's
   // width, all zeros, random values, the start extremes swapped with other fixed values,
   // and random values with headings at or inside the back half's edges, or at half a turn.
   task automatic configure(input int phase);
      case (phase)
         1: begin
            write_reg(REG_START_X, 32'hA5A5_7FFF);
            write_reg(REG_START_Y, 32'h5A5A_8000);
            write_reg(REG_START_HEADING, 32'h1234_FFFF);
            write_reg(REG_LINE_COLOR, 32'hFFFF_FFFF);
            write_reg(REG_LINE_WIDTH, 32'hFFFF_FFFF);
            write_reg(REG_DASH_STYLE, 32'hFFFF_FFFF);
            write_reg(REG_UNUSED_A, 32'hFFFF_FFFF);
         end
         2: begin
            write_reg(REG_START_X, 32'h0000_0000);
            write_reg(REG_START_Y, 32'h0000_0000);
            write_reg(REG_START_HEADING, 32'h0000_0000);
            write_reg(REG_LINE_COLOR, 32'h0000_0000);
            write_reg(REG_LINE_WIDTH, 32'h0000_0000);
            write_reg(REG_DASH_STYLE, 32'h0000_0000);
            write_reg(REG_UNUSED_B, 32'h1234_5678);
         end
         4: begin
            write_reg(REG_START_X, 32'h0000_8000);
            write_reg(REG_START_Y, 32'h0000_7FFF);
            write_reg(REG_START_HEADING, {16'h0000, QUARTER_TURN});
            write_reg(REG_LINE_COLOR, 32'h8000_0001);
            write_reg(REG_LINE_WIDTH, 32'h0000_0080);
            write_reg(REG_DASH_STYLE, 32'h0000_0008);
         end
         3, 5: begin
            write_reg(REG_START_X, $urandom);
            write_reg(REG_START_Y, $urandom);
            if (phase == 5) begin
               case ($urandom_range(0, 3))
                  0: write_reg(REG_START_HEADING, {16'h0000, THREE_QUARTER_TURN});
                  1: write_reg(REG_START_HEADING, {16'h0000, QUARTER_TURN + 16'd1});
                  2: write_reg(REG_START_HEADING, {16'h0000, HALF_TURN});
                  default: write_reg(REG_START_HEADING,
                                     {16'h0000, THREE_QUARTER_TURN - 16'd1});
               endcase
            end else begin
               write_reg(REG_START_HEADING, $urandom);
            end
            write_reg(REG_LINE_COLOR, $urandom);
            write_reg(REG_LINE_WIDTH, $urandom);
            write_reg(REG_DASH_STYLE, $urandom);
         end
         default: begin
         end
      endcase
      csr_we <= 1'b0;
   endtask

   // The receiver raises and drops ready at random; with no stall percentage it
   // always takes the segment word.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !reset && !idle_now(receiver_stall_pct);
      end
   end

   // Every segment word taken is compared, field by field, with the oldest one queued.
   always @(posedge clock) begin : segment_check
      tvce_rsp_type got;
      tvce_rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got = rsp_ch.payload;
         if (segments_due.size() == 0) begin
            report_mismatch("unexpected segment, from_x", 32'(got.from_x), '0);
         end else begin
            want = segments_due.pop_front();
            if (got.from_x !== want.from_x) begin
               report_mismatch("from_x", 32'(got.from_x), 32'(want.from_x));
            end
            if (got.from_y !== want.from_y) begin
               report_mismatch("from_y", 32'(got.from_y), 32'(want.from_y));
            end
            if (got.to_x !== want.to_x) begin
               report_mismatch("to_x", 32'(got.to_x), 32'(want.to_x));
            end
            if (got.to_y !== want.to_y) begin
               report_mismatch("to_y", 32'(got.to_y), 32'(want.to_y));
            end
            if (got.seg_color !== want.seg_color) begin
               report_mismatch("seg_color", got.seg_color, want.seg_color);
            end
            if (got.seg_width !== want.seg_width) begin
               report_mismatch("seg_width", 32'(got.seg_width), 32'(want.seg_width));
            end
            if (got.seg_dash !== want.seg_dash) begin
               report_mismatch("seg_dash", 32'(got.seg_dash), 32'(want.seg_dash));
            end
         end
         segment_number++;
      end
   end

   // Stimulus: reset, the directed opening, then six phases of random commands, each
   // with a register setting and an idling pattern chosen per phase.
   initial begin
      logic [CMD_W-1:0] cmd;
      logic [31:0] amount;
      int known;
      int deg;
      int pick;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_START_X;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      cycle_count = 0;
      mismatch_count = 0;
      segment_number = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      // Reset state: turtle at the origin facing heading zero with the pen down.
      turtle_x = '0;
      turtle_y = '0;
      turtle_heading = '0;
      turtle_pen_low = 1'b1;
      cfg_start_x = '0;
      cfg_start_y = '0;
      cfg_start_heading = '0;
      cfg_color = '0;
      cfg_width = 8'd1;
      cfg_dash = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_rows[r]) begin
         send_word(opening_rows[r].cmd, opening_rows[r].amount,
                   opening_rows[r].typed, opening_rows[r].seg);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         configure(phase);
         case (phase)
            1, 4: begin
               sender_idle_pct = 57;
               receiver_stall_pct = 0;
            end
            2, 5: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 57;
            end
            3: begin
               sender_idle_pct = 12;
               receiver_stall_pct = 12;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
         endcase
         // Start each phase from the new home position.
         send_word(CMD_HOME, $urandom, 1'b0, NO_SEG);
         known = 1;
         while (known < ITEMS_PER_PHASE) begin
            // Mostly moves and turns with the pen down, so most moves draw.
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               cmd = CMD_FORWARD;
            end else if (pick < 70) begin
               cmd = CMD_TURN;
            end else if (pick < 78) begin
               cmd = CMD_PEN_DOWN;
            end else if (pick < 84) begin
               cmd = CMD_PEN_UP;
            end else if (pick < 93) begin
               cmd = CMD_HOME;
            end else begin
               cmd = $urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI);
            end
            // Amounts: half within 200 units either way, some anywhere in the full
            // range, whole multiples of 15 degrees, extremes, and tiny fractions.
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               amount = $urandom_range(0, 32'd26214400) - 32'd13107200;
            end else if (pick < 7) begin
               amount = $urandom;
            end else if (pick == 7) begin
               deg = $urandom_range(0, 24) * 15 - 180;
               amount = deg * 65536;
            end else if (pick == 8) begin
               case ($urandom_range(0, 3))
                  0: amount = 32'h7FFF_FFFF;
                  1: amount = 32'h8000_0000;
                  2: amount = 32'h0000_0000;
                  default: amount = 32'hFFFF_FFFF;
               endcase
            end else begin
               amount = $urandom & 32'h0001_FFFF;
               if ($urandom_range(0, 1) == 1) begin
                  amount = -amount;
               end
            end
            send_word(cmd, amount, 1'b0, NO_SEG);
            if (cmd <= CMD_HOME) begin
               known++;
            end
         end
      end

      drain();
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // A hung handshake ends the run here.
   initial begin
      #(TIMEOUT_NS);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
src/tvce_pkg.sv
src/tvce_if.sv
src/tvce_divider.sv
src/tvce_cordic.sv
src/turtle_vector_command_engine_unit.sv
sim/turtle_vector_command_engine_unit_tb.sv
